// File: design/lte_two_port_precoder_defines.svh
// Assertion macros used by the checker file.
`ifndef LTE_TWO_PORT_PRECODER_DEFINES_SVH
`define LTE_TWO_PORT_PRECODER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define LTE2P_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define LTE2P_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/lte2p_pkg.sv
package lte2p_pkg;

  localparam int SAMPLE_W = 16;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // register map, index = paddr[3:2]
  typedef enum logic [1:0] {
    REG_ANT    = 2'd0,
    REG_SCHEME = 2'd1,
    REG_LAYERS = 2'd2
  } reg_idx_t;

  localparam logic [1:0] ANT_ONE      = 2'd1;
  localparam logic [1:0] ANT_TWO      = 2'd2;
  localparam logic [1:0] SCHEME_OTHER = 2'd0;
  localparam logic [1:0] SCHEME_CDD   = 2'd1;
  localparam logic [1:0] SCHEME_SFBC  = 2'd2;
  localparam logic [2:0] LAYERS_ONE   = 3'd1;
  localparam logic [2:0] LAYERS_TWO   = 3'd2;

  // 1/sqrt2 in Q15, truncated
  localparam logic signed [31:0] INV_SQRT2     = 32'sd23170;
  localparam logic signed [31:0] NEG_INV_SQRT2 = -32'sd23170;

  typedef enum logic [1:0] {
    MODE_NONE,
    MODE_ONE,
    MODE_CDD,
    MODE_SFBC
  } mode_t;

  typedef struct packed {
    sample_t port0_real;
    sample_t port0_imag;
    sample_t port1_real;
    sample_t port1_imag;
    logic    last_of_run;
    logic    end_of_block_out;
  } result_t;

  // floor(c * x / 2^15), low 16 bits
  function automatic sample_t scale_q15(sample_t x, logic signed [31:0] c);
    logic signed [31:0] prod;
    prod = 32'(x) * c;
    return prod[30:15];
  endfunction

endpackage

// File: design/lte2p_in_if.sv
interface lte2p_in_if;
  logic                valid;
  logic                ready;
  lte2p_pkg::sample_t  layer0_real;
  lte2p_pkg::sample_t  layer0_imag;
  lte2p_pkg::sample_t  layer1_real;
  lte2p_pkg::sample_t  layer1_imag;
  logic                odd_index;
  logic                block_end;

  modport source (
    output valid, layer0_real, layer0_imag, layer1_real, layer1_imag, odd_index, block_end,
    input  ready
  );
  modport sink (
    input  valid, layer0_real, layer0_imag, layer1_real, layer1_imag, odd_index, block_end,
    output ready
  );
endinterface

// File: design/lte2p_out_if.sv
interface lte2p_out_if;
  logic                valid;
  logic                ready;
  lte2p_pkg::sample_t  port0_real;
  lte2p_pkg::sample_t  port0_imag;
  lte2p_pkg::sample_t  port1_real;
  lte2p_pkg::sample_t  port1_imag;
  logic                last_of_run;
  logic                end_of_block_out;

  modport source (
    output valid, port0_real, port0_imag, port1_real, port1_imag, last_of_run,
           end_of_block_out,
    input  ready
  );
  modport sink (
    input  valid, port0_real, port0_imag, port1_real, port1_imag, last_of_run,
           end_of_block_out,
    output ready
  );
endinterface

// File: design/lte_two_port_precoder.sv
// A request passes stages 1, 2 and 3, then the output register, on its way to out_ch.
// Throughput: one request per cycle for one-port and large-delay CDD while out_ch does not
// stall; a transmit diversity request holds the pipe until both of its results have entered
// the output register, which takes one result a cycle unless out_ch stalls. Requests under
// an unsupported setting are dropped at entry. Reset (rst_n low, synchronous): empty all
// stages, set antenna_ports 1, tx_scheme 0, layer_count 1.
module lte_two_port_precoder (
  input  logic                              clk,
  input  logic                              rst_n,
  lte2p_in_if.sink                          in_ch,
  lte2p_out_if.source                       out_ch,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lte2p_pkg::ADDR_W-1:0]      paddr,
  input  logic [lte2p_pkg::DATA_W-1:0]      pwdata,
  output logic [lte2p_pkg::DATA_W-1:0]      prdata,
  output logic                              pready
);

  // Entry stage payload: decoded mode plus the raw symbols.
  typedef struct packed {
    lte2p_pkg::mode_t   mode;
    logic               odd;
    logic               eob;
    lte2p_pkg::sample_t r0;
    lte2p_pkg::sample_t i0;
    lte2p_pkg::sample_t r1;
    lte2p_pkg::sample_t i1;
  } entry_t;

  // After the multiply stage: raw symbols plus the six 1/sqrt2 products.
  typedef struct packed {
    entry_t             base;
    lte2p_pkg::sample_t s_r0;
    lte2p_pkg::sample_t s_i0;
    lte2p_pkg::sample_t s_r1;
    lte2p_pkg::sample_t s_i1;
    lte2p_pkg::sample_t n_r1;
    lte2p_pkg::sample_t n_i0;
  } scaled_t;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [1:0] ant_r,    ant_nxt;
  logic [1:0] scheme_r, scheme_nxt;
  logic [2:0] layers_r, layers_nxt;
  logic       cfg_wr;
  lte2p_pkg::reg_idx_t cfg_idx;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign cfg_idx = lte2p_pkg::reg_idx_t'(paddr[3:2]);

  // Write the addressed register; ignore addresses past the map.
  always_comb begin
    ant_nxt    = ant_r;
    scheme_nxt = scheme_r;
    layers_nxt = layers_r;
    if (cfg_wr) begin
      unique case (cfg_idx)
        lte2p_pkg::REG_ANT:    ant_nxt    = pwdata[1:0];
        lte2p_pkg::REG_SCHEME: scheme_nxt = pwdata[1:0];
        lte2p_pkg::REG_LAYERS: layers_nxt = pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      lte2p_pkg::REG_ANT:    prdata = {30'd0, ant_r};
      lte2p_pkg::REG_SCHEME: prdata = {30'd0, scheme_r};
      lte2p_pkg::REG_LAYERS: prdata = {29'd0, layers_r};
      default:               prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Mode decode at entry. The user must keep the setting static while requests are in
  // flight; the block does not enforce it. Decode once and carry the mode down the pipe.
  // ---------------------------------------------------------------------------
  lte2p_pkg::mode_t mode_in;

  always_comb begin
    priority if (ant_r == lte2p_pkg::ANT_ONE) begin
      mode_in = lte2p_pkg::MODE_ONE;
    end else if (ant_r == lte2p_pkg::ANT_TWO && layers_r == lte2p_pkg::LAYERS_TWO &&
                 scheme_r == lte2p_pkg::SCHEME_CDD) begin
      mode_in = lte2p_pkg::MODE_CDD;
    end else if (ant_r == lte2p_pkg::ANT_TWO && layers_r == lte2p_pkg::LAYERS_TWO &&
                 scheme_r == lte2p_pkg::SCHEME_SFBC) begin
      mode_in = lte2p_pkg::MODE_SFBC;
    end else begin
      mode_in = lte2p_pkg::MODE_NONE;
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control. All three stages advance together whenever the last
  // stage is empty or hands over its final result this cycle; a stall freezes
  // every stage in place, so nothing is lost or repeated.
  // ---------------------------------------------------------------------------
  logic    v1_r, v1_nxt;
  logic    v2_r, v2_nxt;
  logic    v3_r, v3_nxt;
  logic    phase_r, phase_nxt;   // 1 while the second transmit diversity result waits
  logic    out_v_r, out_v_nxt;
  entry_t  s1_r, s1_nxt;
  scaled_t s2_r, s2_nxt;
  scaled_t s3_r, s3_nxt;
  lte2p_pkg::result_t out_r, out_nxt;

  logic    adv;
  logic    in_accept;
  logic    out_load;
  logic    s3_last;
  lte2p_pkg::result_t res_sel;

  // Stage 3 is done after its only result, or after the second of a pair.
  assign s3_last  = (s3_r.base.mode != lte2p_pkg::MODE_SFBC) || phase_r;
  // Load the output register when it is empty or being drained.
  assign out_load = v3_r && (!out_v_r || out_ch.ready);
  assign adv      = !v3_r || (out_load && s3_last);

  // Hold off requests while reset is applied.
  assign in_ch.ready = adv && rst_n;
  assign in_accept   = in_ch.valid && adv;

  always_comb begin
    v1_nxt    = v1_r;
    v2_nxt    = v2_r;
    v3_nxt    = v3_r;
    phase_nxt = phase_r;
    if (adv) begin
      // Drop requests under an unsupported setting right here.
      v1_nxt = in_accept && (mode_in != lte2p_pkg::MODE_NONE);
      v2_nxt = v1_r;
      v3_nxt = v2_r;
    end
    if (out_load) begin
      phase_nxt = !s3_last;
    end
    out_v_nxt = out_load ? 1'b1 : (out_ch.ready ? 1'b0 : out_v_r);
  end

  // ---------------------------------------------------------------------------
  // Stage 1: capture the request.
  // ---------------------------------------------------------------------------
  always_comb begin
    s1_nxt = s1_r;
    if (adv) begin
      s1_nxt.mode = mode_in;
      s1_nxt.odd  = in_ch.odd_index;
      s1_nxt.eob  = in_ch.block_end;
      s1_nxt.r0   = in_ch.layer0_real;
      s1_nxt.i0   = in_ch.layer0_imag;
      s1_nxt.r1   = in_ch.layer1_real;
      s1_nxt.i1   = in_ch.layer1_imag;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: constant multiplies by +/- 1/sqrt2, keep bits [30:15].
  // ---------------------------------------------------------------------------
  always_comb begin
    s2_nxt = s2_r;
    if (adv) begin
      s2_nxt.base = s1_r;
      s2_nxt.s_r0 = lte2p_pkg::scale_q15(s1_r.r0, lte2p_pkg::INV_SQRT2);
      s2_nxt.s_i0 = lte2p_pkg::scale_q15(s1_r.i0, lte2p_pkg::INV_SQRT2);
      s2_nxt.s_r1 = lte2p_pkg::scale_q15(s1_r.r1, lte2p_pkg::INV_SQRT2);
      s2_nxt.s_i1 = lte2p_pkg::scale_q15(s1_r.i1, lte2p_pkg::INV_SQRT2);
      s2_nxt.n_r1 = lte2p_pkg::scale_q15(s1_r.r1, lte2p_pkg::NEG_INV_SQRT2);
      s2_nxt.n_i0 = lte2p_pkg::scale_q15(s1_r.i0, lte2p_pkg::NEG_INV_SQRT2);
    end
  end

  // Stage 3 just holds stage 2's word until its results are out.
  assign s3_nxt = adv ? s2_r : s3_r;

  // ---------------------------------------------------------------------------
  // Result select from stage 3: CDD halving adds, transmit diversity products, or layer 0 for one port.
  // ---------------------------------------------------------------------------
  lte2p_pkg::sample_t hr0, hi0, hr1, hi1;

  assign hr0 = s3_r.base.r0 >>> 1;
  assign hi0 = s3_r.base.i0 >>> 1;
  assign hr1 = s3_r.base.r1 >>> 1;
  assign hi1 = s3_r.base.i1 >>> 1;

  always_comb begin
    res_sel.port0_real       = s3_r.base.r0;
    res_sel.port0_imag       = s3_r.base.i0;
    res_sel.port1_real       = '0;
    res_sel.port1_imag       = '0;
    res_sel.last_of_run      = 1'b1;
    res_sel.end_of_block_out = s3_r.base.eob;
    unique case (s3_r.base.mode)
      lte2p_pkg::MODE_CDD: begin
        // Sum on port 0; difference on port 1, order swapped on odd index.
        res_sel.port0_real = hr0 + hr1;
        res_sel.port0_imag = hi0 + hi1;
        res_sel.port1_real = s3_r.base.odd ? hr1 - hr0 : hr0 - hr1;
        res_sel.port1_imag = s3_r.base.odd ? hi1 - hi0 : hi0 - hi1;
      end
      lte2p_pkg::MODE_SFBC: begin
        if (!phase_r) begin
          // First of the pair: x0 and -conj(x1).
          res_sel.port0_real       = s3_r.s_r0;
          res_sel.port0_imag       = s3_r.s_i0;
          res_sel.port1_real       = s3_r.n_r1;
          res_sel.port1_imag       = s3_r.s_i1;
          res_sel.last_of_run      = 1'b0;
          res_sel.end_of_block_out = 1'b0;
        end else begin
          // Second of the pair: x1 and conj(x0).
          res_sel.port0_real = s3_r.s_r1;
          res_sel.port0_imag = s3_r.s_i1;
          res_sel.port1_real = s3_r.s_r0;
          res_sel.port1_imag = s3_r.n_i0;
        end
      end
      default: ;  // one port: pass layer 0 through
    endcase
  end

  assign out_nxt = out_load ? res_sel : out_r;

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ant_r    <= lte2p_pkg::ANT_ONE;
      scheme_r <= lte2p_pkg::SCHEME_OTHER;
      layers_r <= lte2p_pkg::LAYERS_ONE;
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      v3_r     <= 1'b0;
      phase_r  <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      ant_r    <= ant_nxt;
      scheme_r <= scheme_nxt;
      layers_r <= layers_nxt;
      v1_r     <= v1_nxt;
      v2_r     <= v2_nxt;
      v3_r     <= v3_nxt;
      phase_r  <= phase_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_r  <= s1_nxt;
    s2_r  <= s2_nxt;
    s3_r  <= s3_nxt;
    out_r <= out_nxt;
  end

  // ---------------------------------------------------------------------------
  // Output channel
  // ---------------------------------------------------------------------------
  assign out_ch.valid            = out_v_r;
  assign out_ch.port0_real       = out_r.port0_real;
  assign out_ch.port0_imag       = out_r.port0_imag;
  assign out_ch.port1_real       = out_r.port1_real;
  assign out_ch.port1_imag       = out_r.port1_imag;
  assign out_ch.last_of_run      = out_r.last_of_run;
  assign out_ch.end_of_block_out = out_r.end_of_block_out;

endmodule

// File: design/lte2p_checker.sv
`include "lte_two_port_precoder_defines.svh"

module lte2p_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input lte2p_pkg::sample_t           out_p0r,
  input lte2p_pkg::sample_t           out_p0i,
  input lte2p_pkg::sample_t           out_p1r,
  input lte2p_pkg::sample_t           out_p1i,
  input logic                         out_last,
  input logic                         out_eob,
  input logic                         psel,
  input logic                         penable,
  input logic                         pwrite,
  input logic                         pready,
  input logic [lte2p_pkg::ADDR_W-1:0] paddr,
  input logic [lte2p_pkg::DATA_W-1:0] pwdata
);

  // Track the antenna port count from the write requests seen on the bus.
  logic [1:0] ant_sh_r, ant_sh_nxt;

  always_comb begin
    ant_sh_nxt = ant_sh_r;
    if (psel && penable && pwrite && pready &&
        paddr[3:2] == lte2p_pkg::REG_ANT) begin
      ant_sh_nxt = pwdata[1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ant_sh_r <= lte2p_pkg::ANT_ONE;
    end else begin
      ant_sh_r <= ant_sh_nxt;
    end
  end

  `LTE2P_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable({out_p0r, out_p0i, out_p1r, out_p1i, out_last, out_eob}),
    "stalled result changed or vanished")

  `LTE2P_ASSERT_NEXT(a_pair_follows, out_valid && out_ready && !out_last,
    out_valid && out_last, "second result of a pair did not follow at once")

  `LTE2P_ASSERT_SAME(a_first_no_eob, out_valid && !out_last, !out_eob,
    "block end flagged on a non-final result")

  `LTE2P_ASSERT_SAME(a_one_port, out_valid && ant_sh_r == lte2p_pkg::ANT_ONE,
    out_p1r == '0 && out_p1i == '0 && out_last, "one-port result not single or port 1 busy")

endmodule

bind lte_two_port_precoder lte2p_checker u_lte2p_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_p0r   (out_ch.port0_real),
  .out_p0i   (out_ch.port0_imag),
  .out_p1r   (out_ch.port1_real),
  .out_p1i   (out_ch.port1_imag),
  .out_last  (out_ch.last_of_run),
  .out_eob   (out_ch.end_of_block_out),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .pready    (pready),
  .paddr     (paddr),
  .pwdata    (pwdata)
);

// File: tb/testbench.sv
module testbench;

  // Timeout: the longest quiet spell of a correct run is the receiver hold-off
  // below, plus a reconfiguration. Keep a wide margin over both.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLDOFF_CYCLES = 300;
  // Drain after the last pending result, to catch stray results.
  localparam int DRAIN_CYCLES   = 8;
  localparam int MAX_REPORTS    = 10;

  // Codes outside the package's named set, used to reach the unsupported settings and the spare address.
  localparam logic [1:0]         SCHEME_RSVD = 2'd3;
  localparam logic [1:0]         REG_SPARE   = 2'd3;
  localparam lte2p_pkg::result_t NO_RESULT   = '0;

  typedef struct packed {
    lte2p_pkg::sample_t l0_re;
    lte2p_pkg::sample_t l0_im;
    lte2p_pkg::sample_t l1_re;
    lte2p_pkg::sample_t l1_im;
    logic               odd_index;
    logic               block_end;
  } symbol_pair_t;

  // Directed request: the setting it runs under, the request itself and,
  // where n_typed >= 0, the results spelled out by hand.
  typedef struct {
    logic [1:0]         ports;
    logic [1:0]         scheme;
    logic [2:0]         layers;
    symbol_pair_t       sym;
    int                 n_typed;
    lte2p_pkg::result_t want0;
    lte2p_pkg::result_t want1;
  } directed_row_t;

  typedef struct {
    logic [1:0] ports;
    logic [1:0] scheme;
    logic [2:0] layers;
    int         requests;
    bit         squeeze;
  } setting_t;

  logic                          clk;
  logic                          rst_n;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [lte2p_pkg::ADDR_W-1:0]  paddr;
  logic [lte2p_pkg::DATA_W-1:0]  pwdata;
  logic [lte2p_pkg::DATA_W-1:0]  prdata;
  logic                          pready;

  lte2p_in_if  sym_in ();
  lte2p_out_if port_out ();

  lte_two_port_precoder u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (sym_in),
    .out_ch  (port_out),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow copy of the registers, as the precoder should hold them.
  logic [1:0] ports_cfg;
  logic [1:0] scheme_cfg;
  logic [2:0] layers_cfg;

  lte2p_pkg::result_t port_expect_q[$];
  directed_row_t      directed_rows[$];
  setting_t           plan[$];
  int                 mismatches;
  int                 idle_pct;
  int                 stall_pct;
  bit                 holdoff_req;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // floor(+-(1/sqrt2) * x) in Q15, kept to 16 bits
  function automatic lte2p_pkg::sample_t q15_scale(lte2p_pkg::sample_t x, bit negate);
    int prod;
    prod = int'(x) * (negate ? -int'(lte2p_pkg::INV_SQRT2)
                             : int'(lte2p_pkg::INV_SQRT2));
    return lte2p_pkg::sample_t'(prod >>> 15);
  endfunction

  // Map one layer pair onto the antenna ports under the current shadow setting.
  // Returns how many port results the request should produce.
  function automatic int precode_pair(input symbol_pair_t s,
                                      output lte2p_pkg::result_t first,
                                      output lte2p_pkg::result_t second);
    lte2p_pkg::sample_t h0r, h0i, h1r, h1i;
    first  = NO_RESULT;
    second = NO_RESULT;
    // One port: layer 0 straight through, whatever the other registers hold.
    if (ports_cfg == lte2p_pkg::ANT_ONE) begin
      first = '{s.l0_re, s.l0_im, '0, '0, 1'b1, s.block_end};
      return 1;
    end
    if (ports_cfg != lte2p_pkg::ANT_TWO || layers_cfg != lte2p_pkg::LAYERS_TWO) return 0;
    case (scheme_cfg)
      lte2p_pkg::SCHEME_CDD: begin
        // Halve first, then sum and difference; wrap at 16 bits.
        h0r = lte2p_pkg::sample_t'(s.l0_re) >>> 1;
        h0i = lte2p_pkg::sample_t'(s.l0_im) >>> 1;
        h1r = lte2p_pkg::sample_t'(s.l1_re) >>> 1;
        h1i = lte2p_pkg::sample_t'(s.l1_im) >>> 1;
        first.port0_real       = h0r + h1r;
        first.port0_imag       = h0i + h1i;
        first.port1_real       = s.odd_index ? h1r - h0r : h0r - h1r;
        first.port1_imag       = s.odd_index ? h1i - h0i : h0i - h1i;
        first.last_of_run      = 1'b1;
        first.end_of_block_out = s.block_end;
        return 1;
      end
      lte2p_pkg::SCHEME_SFBC: begin
        // x0 on port 0 with -conj(x1) on port 1, then x1 with conj(x0).
        first  = '{q15_scale(s.l0_re, 1'b0), q15_scale(s.l0_im, 1'b0),
                   q15_scale(s.l1_re, 1'b1), q15_scale(s.l1_im, 1'b0), 1'b0, 1'b0};
        second = '{q15_scale(s.l1_re, 1'b0), q15_scale(s.l1_im, 1'b0),
                   q15_scale(s.l0_re, 1'b0), q15_scale(s.l0_im, 1'b1), 1'b1, s.block_end};
        return 2;
      end
      default: return 0;
    endcase
  endfunction

  function automatic void expect_precoded(input symbol_pair_t s);
    lte2p_pkg::result_t first, second;
    int n;
    n = precode_pair(s, first, second);
    if (n >= 1) port_expect_q.push_back(first);
    if (n == 2) port_expect_q.push_back(second);
  endfunction

  // Mostly full-scale random, with the corner values drawn often.
  function automatic lte2p_pkg::sample_t rand_sample();
    case ($urandom_range(9))
      0:       return 16'sh7fff;
      1:       return 16'sh8000;
      2:       return 16'sh0000;
      3:       return -16'sd1;
      default: return lte2p_pkg::sample_t'($urandom);
    endcase
  endfunction

  task automatic add_row(input logic [1:0] ports, input logic [1:0] scheme,
                         input logic [2:0] layers, input symbol_pair_t sym,
                         input int n_typed, input lte2p_pkg::result_t want0,
                         input lte2p_pkg::result_t want1);
    directed_rows.push_back('{ports, scheme, layers, sym, n_typed, want0, want1});
  endtask

  // Offer one request, idling at random first; return at the accepting edge.
  task automatic send_pair(input symbol_pair_t s);
    while ($urandom_range(99) < idle_pct) begin
      sym_in.valid <= 1'b0;
      @(posedge clk);
    end
    sym_in.valid       <= 1'b1;
    sym_in.layer0_real <= s.l0_re;
    sym_in.layer0_imag <= s.l0_im;
    sym_in.layer1_real <= s.l1_re;
    sym_in.layer1_imag <= s.l1_im;
    sym_in.odd_index   <= s.odd_index;
    sym_in.block_end   <= s.block_end;
    do @(posedge clk); while (!sym_in.ready);
  endtask

  // Drop valid, wait for every pending result, then cover requests the block
  // is still dropping and the pipeline depth.
  task automatic settle();
    sym_in.valid <= 1'b0;
    while (port_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Setup then access; psel and penable stay up until the next setup or the
  // explicit release, so each signal changes at most once per edge.
  task automatic apb_write(input logic [1:0] idx, input logic [lte2p_pkg::DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= lte2p_pkg::ADDR_W'({idx, 2'b00});
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic apb_read(input logic [1:0] idx, output logic [lte2p_pkg::DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= lte2p_pkg::ADDR_W'({idx, 2'b00});
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    data = prdata;
  endtask

  // Reprogram all registers while the block is idle. Upper bits carry junk
  // that the block must mask off; the spare address takes junk and must not
  // disturb anything. Read every register back.
  task automatic apply_setting(input logic [1:0] ports, input logic [1:0] scheme,
                               input logic [2:0] layers);
    logic [lte2p_pkg::DATA_W-1:0] wr [3];
    logic [lte2p_pkg::DATA_W-1:0] want [3];
    logic [lte2p_pkg::DATA_W-1:0] rd;
    settle();
    wr[0] = $urandom;
    wr[1] = $urandom;
    wr[2] = $urandom;
    wr[0][1:0] = ports;
    wr[1][1:0] = scheme;
    wr[2][2:0] = layers;
    want[0] = lte2p_pkg::DATA_W'(ports);
    want[1] = lte2p_pkg::DATA_W'(scheme);
    want[2] = lte2p_pkg::DATA_W'(layers);
    apb_write(lte2p_pkg::REG_ANT, wr[0]);
    apb_write(lte2p_pkg::REG_SCHEME, wr[1]);
    apb_write(lte2p_pkg::REG_LAYERS, wr[2]);
    apb_write(REG_SPARE, $urandom);
    for (int i = 0; i < 3; i++) begin
      apb_read(2'(i), rd);
      if (rd !== want[i]) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("register %0d readback: expected %0h, got %0h", i, want[i], rd);
      end
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    ports_cfg  = ports;
    scheme_cfg = scheme;
    layers_cfg = layers;
  endtask

  // Result side: stall at random, honor a hold-off request, and compare each
  // accepted result against the oldest pending one.
  initial begin
    int holdoff_left;
    lte2p_pkg::result_t got, want;
    holdoff_left = 0;
    port_out.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && port_out.valid && port_out.ready) begin
        got = '{port_out.port0_real, port_out.port0_imag, port_out.port1_real,
                port_out.port1_imag, port_out.last_of_run, port_out.end_of_block_out};
        if (port_expect_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected port result: %0d %0d %0d %0d last=%0b eob=%0b",
                     got.port0_real, got.port0_imag, got.port1_real, got.port1_imag,
                     got.last_of_run, got.end_of_block_out);
        end else begin
          want = port_expect_q.pop_front();
          if (got.port0_real !== want.port0_real || got.port0_imag !== want.port0_imag ||
              got.port1_real !== want.port1_real || got.port1_imag !== want.port1_imag ||
              got.last_of_run !== want.last_of_run ||
              got.end_of_block_out !== want.end_of_block_out) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("port mismatch: expected %h, got %h", want, got);
          end
        end
      end
      if (holdoff_req) begin
        holdoff_left = HOLDOFF_CYCLES;
        holdoff_req  = 1'b0;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        port_out.ready <= 1'b0;
      end else begin
        port_out.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Stop the run if neither channel moves a request for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (sym_in.valid && sym_in.ready) || (port_out.valid && port_out.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int idle_in [4];
    int idle_out [4];
    int sym_idx;
    int block_len;
    symbol_pair_t s;
    idle_in  = '{0, 61, 0, 28};
    idle_out = '{0, 0, 61, 28};
    mismatches  = 0;
    holdoff_req = 1'b0;
    idle_pct    = 0;
    stall_pct   = 0;
    sym_idx     = 0;
    block_len   = 1;

    // Drive every input to a known value before the first edge.
    rst_n              <= 1'b0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    sym_in.valid       <= 1'b0;
    sym_in.layer0_real <= '0;
    sym_in.layer0_imag <= '0;
    sym_in.layer1_real <= '0;
    sym_in.layer1_imag <= '0;
    sym_in.odd_index   <= 1'b0;
    sym_in.block_end   <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Registers as they come out of reset.
    ports_cfg  = lte2p_pkg::ANT_ONE;
    scheme_cfg = lte2p_pkg::SCHEME_OTHER;
    layers_cfg = lte2p_pkg::LAYERS_ONE;

    // Directed requests. Rows with -1 go through the predictor.
    // Reset setting: one port passes layer 0 through.
    add_row(lte2p_pkg::ANT_ONE, lte2p_pkg::SCHEME_OTHER, lte2p_pkg::LAYERS_ONE,
            '{16'sh7fff, 16'sh8000, 16'sd123, -16'sd456, 1'b0, 1'b1}, 1,
            '{16'sh7fff, 16'sh8000, 16'sd0, 16'sd0, 1'b1, 1'b1}, NO_RESULT);
    add_row(lte2p_pkg::ANT_ONE, lte2p_pkg::SCHEME_OTHER, lte2p_pkg::LAYERS_ONE,
            '{16'sd0, -16'sd1, 16'sh8000, 16'sh7fff, 1'b1, 1'b0}, 1,
            '{16'sd0, -16'sd1, 16'sd0, 16'sd0, 1'b1, 1'b0}, NO_RESULT);
    // One port ignores scheme and layer count.
    add_row(lte2p_pkg::ANT_ONE, lte2p_pkg::SCHEME_SFBC, lte2p_pkg::LAYERS_TWO,
            '{16'sh8000, 16'sh7fff, 16'sd5, 16'sd6, 1'b0, 1'b1}, 1,
            '{16'sh8000, 16'sh7fff, 16'sd0, 16'sd0, 1'b1, 1'b1}, NO_RESULT);
    // Large-delay CDD at full scale, both index parities, and -1 halving.
    add_row(lte2p_pkg::ANT_TWO, lte2p_pkg::SCHEME_CDD, lte2p_pkg::LAYERS_TWO,
            '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0, 1'b0}, 1,
            '{16'sd32766, 16'sd32766, 16'sd0, 16'sd0, 1'b1, 1'b0}, NO_RESULT);
    add_row(lte2p_pkg::ANT_TWO, lte2p_pkg::SCHEME_CDD, lte2p_pkg::LAYERS_TWO,
            '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b1, 1'b1}, 1,
            '{16'sh8000, 16'sh8000, 16'sd0, 16'sd0, 1'b1, 1'b1}, NO_RESULT);
    add_row(lte2p_pkg::ANT_TWO, lte2p_pkg::SCHEME_CDD, lte2p_pkg::LAYERS_TWO,
            '{16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 1'b0, 1'b0}, 1,
            '{-16'sd1, -16'sd1, 16'sd32767, -16'sd32767, 1'b1, 1'b0}, NO_RESULT);
    add_row(lte2p_pkg::ANT_TWO, lte2p_pkg::SCHEME_CDD, lte2p_pkg::LAYERS_TWO,
            '{16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 1'b1, 1'b1}, 1,
            '{-16'sd1, -16'sd1, -16'sd32767, 16'sd32767, 1'b1, 1'b1}, NO_RESULT);
    add_row(lte2p_pkg::ANT_TWO, lte2p_pkg::SCHEME_CDD, lte2p_pkg::LAYERS_TWO,
            '{-16'sd1, 16'sd1, 16'sd1, -16'sd1, 1'b0, 1'b0}, 1,
            '{-16'sd1, -16'sd1, -16'sd1, 16'sd1, 1'b1, 1'b0}, NO_RESULT);
    add_row(lte2p_pkg::ANT_TWO, lte2p_pkg::SCHEME_CDD, lte2p_pkg::LAYERS_TWO,
            '{16'sd12345, -16'sd23456, -16'sd7, 16'sd9999, 1'b1, 1'b0}, -1,
            NO_RESULT, NO_RESULT);
    // Transmit diversity: extremes, zero, small values.
    add_row(lte2p_pkg::ANT_TWO, lte2p_pkg::SCHEME_SFBC, lte2p_pkg::LAYERS_TWO,
            '{16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 1'b0, 1'b1}, 2,
            '{16'sd23169, -16'sd23170, 16'sd23170, 16'sd23169, 1'b0, 1'b0},
            '{-16'sd23170, 16'sd23169, 16'sd23169, 16'sd23170, 1'b1, 1'b1});
    add_row(lte2p_pkg::ANT_TWO, lte2p_pkg::SCHEME_SFBC, lte2p_pkg::LAYERS_TWO,
            '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b0}, 2,
            NO_RESULT, '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b0});
    add_row(lte2p_pkg::ANT_TWO, lte2p_pkg::SCHEME_SFBC, lte2p_pkg::LAYERS_TWO,
            '{-16'sd1, 16'sd1, 16'sd1, -16'sd1, 1'b1, 1'b1}, -1, NO_RESULT, NO_RESULT);
    add_row(lte2p_pkg::ANT_TWO, lte2p_pkg::SCHEME_SFBC, lte2p_pkg::LAYERS_TWO,
            '{16'sd1000, -16'sd2000, 16'sd30000, -16'sd30000, 1'b0, 1'b0}, -1,
            NO_RESULT, NO_RESULT);
    // Unsupported settings: every request dropped.
    add_row(lte2p_pkg::ANT_TWO, lte2p_pkg::SCHEME_OTHER, lte2p_pkg::LAYERS_TWO,
            '{16'sd11, 16'sd12, 16'sd13, 16'sd14, 1'b0, 1'b1}, 0, NO_RESULT, NO_RESULT);
    add_row(lte2p_pkg::ANT_TWO, SCHEME_RSVD, lte2p_pkg::LAYERS_TWO,
            '{16'sd21, 16'sd22, 16'sd23, 16'sd24, 1'b1, 1'b1}, 0, NO_RESULT, NO_RESULT);
    add_row(lte2p_pkg::ANT_TWO, lte2p_pkg::SCHEME_CDD, lte2p_pkg::LAYERS_ONE,
            '{16'sd31, 16'sd32, 16'sd33, 16'sd34, 1'b0, 1'b1}, 0, NO_RESULT, NO_RESULT);
    add_row(lte2p_pkg::ANT_TWO, lte2p_pkg::SCHEME_SFBC, 3'd3,
            '{16'sd41, 16'sd42, 16'sd43, 16'sd44, 1'b1, 1'b1}, 0, NO_RESULT, NO_RESULT);
    add_row(2'd0, lte2p_pkg::SCHEME_CDD, lte2p_pkg::LAYERS_TWO,
            '{16'sd51, 16'sd52, 16'sd53, 16'sd54, 1'b0, 1'b1}, 0, NO_RESULT, NO_RESULT);
    add_row(2'd3, lte2p_pkg::SCHEME_SFBC, lte2p_pkg::LAYERS_TWO,
            '{16'sd61, 16'sd62, 16'sd63, 16'sd64, 1'b1, 1'b1}, 0, NO_RESULT, NO_RESULT);
    add_row(lte2p_pkg::ANT_TWO, lte2p_pkg::SCHEME_SFBC, 3'd4,
            '{16'sd71, 16'sd72, 16'sd73, 16'sd74, 1'b0, 1'b1}, 0, NO_RESULT, NO_RESULT);
    // Recover from the dropped settings.
    add_row(lte2p_pkg::ANT_TWO, lte2p_pkg::SCHEME_SFBC, lte2p_pkg::LAYERS_TWO,
            '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b0, 1'b1}, 2,
            '{-16'sd23170, -16'sd23170, 16'sd23170, -16'sd23170, 1'b0, 1'b0},
            '{-16'sd23170, -16'sd23170, -16'sd23170, 16'sd23170, 1'b1, 1'b1});
    add_row(lte2p_pkg::ANT_TWO, lte2p_pkg::SCHEME_CDD, lte2p_pkg::LAYERS_TWO,
            '{-16'sd3, 16'sd20001, 16'sd77, -16'sd32000, 1'b1, 1'b1}, -1,
            NO_RESULT, NO_RESULT);
    add_row(lte2p_pkg::ANT_ONE, lte2p_pkg::SCHEME_OTHER, lte2p_pkg::LAYERS_ONE,
            '{16'sd7, -16'sd7, 16'sd8, -16'sd8, 1'b1, 1'b0}, 1,
            '{16'sd7, -16'sd7, 16'sd0, 16'sd0, 1'b1, 1'b0}, NO_RESULT);

    idle_pct  = 28;
    stall_pct = 28;
    foreach (directed_rows[i]) begin
      if ({directed_rows[i].ports, directed_rows[i].scheme, directed_rows[i].layers} !=
          {ports_cfg, scheme_cfg, layers_cfg})
        apply_setting(directed_rows[i].ports, directed_rows[i].scheme,
                      directed_rows[i].layers);
      send_pair(directed_rows[i].sym);
      if (directed_rows[i].n_typed < 0) begin
        expect_precoded(directed_rows[i].sym);
      end else begin
        if (directed_rows[i].n_typed >= 1) port_expect_q.push_back(directed_rows[i].want0);
        if (directed_rows[i].n_typed == 2) port_expect_q.push_back(directed_rows[i].want1);
      end
    end

    // Random part: each setting runs through all four idling profiles.
    // Unsupported settings get only a handful of requests.
    plan.push_back('{lte2p_pkg::ANT_TWO, lte2p_pkg::SCHEME_SFBC, lte2p_pkg::LAYERS_TWO,
                     400, 1'b1});
    plan.push_back('{lte2p_pkg::ANT_ONE, lte2p_pkg::SCHEME_OTHER, lte2p_pkg::LAYERS_ONE,
                     150, 1'b0});
    plan.push_back('{lte2p_pkg::ANT_TWO, lte2p_pkg::SCHEME_CDD, lte2p_pkg::LAYERS_TWO,
                     400, 1'b0});
    plan.push_back('{2'd0, lte2p_pkg::SCHEME_CDD, lte2p_pkg::LAYERS_TWO, 12, 1'b0});
    plan.push_back('{lte2p_pkg::ANT_ONE, SCHEME_RSVD, 3'd7, 150, 1'b0});
    plan.push_back('{lte2p_pkg::ANT_TWO, SCHEME_RSVD, lte2p_pkg::LAYERS_TWO, 12, 1'b0});
    plan.push_back('{lte2p_pkg::ANT_TWO, lte2p_pkg::SCHEME_SFBC, 3'd4, 12, 1'b0});
    plan.push_back('{lte2p_pkg::ANT_TWO, lte2p_pkg::SCHEME_CDD, lte2p_pkg::LAYERS_TWO,
                     200, 1'b0});
    plan.push_back('{lte2p_pkg::ANT_ONE, lte2p_pkg::SCHEME_CDD, 3'd0, 150, 1'b0});
    plan.push_back('{lte2p_pkg::ANT_TWO, lte2p_pkg::SCHEME_OTHER, lte2p_pkg::LAYERS_TWO,
                     12, 1'b0});
    plan.push_back('{lte2p_pkg::ANT_TWO, lte2p_pkg::SCHEME_CDD, 3'd3, 12, 1'b0});
    plan.push_back('{lte2p_pkg::ANT_TWO, lte2p_pkg::SCHEME_SFBC, lte2p_pkg::LAYERS_TWO,
                     300, 1'b0});
    plan.push_back('{2'd3, lte2p_pkg::SCHEME_SFBC, lte2p_pkg::LAYERS_TWO, 12, 1'b0});
    plan.push_back('{lte2p_pkg::ANT_TWO, lte2p_pkg::SCHEME_SFBC, 3'd0, 12, 1'b0});
    plan.push_back('{lte2p_pkg::ANT_TWO, lte2p_pkg::SCHEME_CDD, lte2p_pkg::LAYERS_ONE,
                     12, 1'b0});

    foreach (plan[p]) begin
      apply_setting(plan[p].ports, plan[p].scheme, plan[p].layers);
      for (int ph = 0; ph < 4; ph++) begin
        idle_pct  = idle_in[ph];
        stall_pct = idle_out[ph];
        // Hold the result side off while requests keep coming, to back the
        // block up into its input.
        if (plan[p].squeeze && ph == 0) holdoff_req = 1'b1;
        for (int k = 0; k < plan[p].requests / 4; k++) begin
          // Symbol blocks of random length; index parity and block end follow
          // the position, with an occasional scrambled request.
          if (sym_idx >= block_len) begin
            sym_idx   = 0;
            block_len = $urandom_range(1, 12);
          end
          s.l0_re     = rand_sample();
          s.l0_im     = rand_sample();
          s.l1_re     = rand_sample();
          s.l1_im     = rand_sample();
          s.odd_index = sym_idx[0];
          s.block_end = (sym_idx == block_len - 1);
          if ($urandom_range(7) == 0) begin
            s.odd_index = 1'($urandom);
            s.block_end = 1'($urandom);
          end
          sym_idx++;
          send_pair(s);
          expect_precoded(s);
        end
      end
    end

    settle();
    if (mismatches == 0 && port_expect_q.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// File: files.f
+incdir+design
design/lte2p_pkg.sv
design/lte2p_in_if.sv
design/lte2p_out_if.sv
design/lte_two_port_precoder.sv
design/lte2p_checker.sv
tb/testbench.sv
